### rtl/core/spt_pkg.sv
// Shared types and constants of the similarity point transform.
package spt_pkg;

  // Fixed formats
  localparam int QUAT_FRAC_BITS = 30;
  localparam int COORD_W        = 32;
  localparam int ENTRY_W        = 36;                // rotation entry, signed Q30
  localparam int QPROD_W        = 2 * COORD_W;       // quaternion component product
  localparam int QSUM_W         = QPROD_W + 2;       // matrix entry before rounding, Q60
  localparam int PROD_W         = ENTRY_W + COORD_W; // entry times coordinate
  localparam int SUM_W          = PROD_W + 2;        // row sum of three products
  localparam int SPLIT_W        = 35;                // low part of the row sum for scaling
  localparam int HI_W           = SUM_W - SPLIT_W;
  localparam int LO_PROD_W      = SPLIT_W + COORD_W;
  localparam int HI_PROD_W      = HI_W + COORD_W + 1;
  localparam int ACC_W          = 104;               // scaled sum plus translation

  // Datapath stages from input capture to output register
  localparam int NUM_STAGES = 7;

  // Register map
  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = 5;
  localparam int IDX_W    = 3;
  localparam logic [IDX_W-1:0] REG_SCALE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_QUAT_REAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_QUAT_X    = 3'd2;
  localparam logic [IDX_W-1:0] REG_QUAT_Y    = 3'd3;
  localparam logic [IDX_W-1:0] REG_QUAT_Z    = 3'd4;
  localparam logic [IDX_W-1:0] REG_SHIFT_X   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SHIFT_Y   = 3'd6;
  localparam logic [IDX_W-1:0] REG_SHIFT_Z   = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [COORD_W-1:0] ucoord_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef entry_t mat_t [3][3];
  typedef coord_t vec_t [3];
  typedef sum_t   sum_vec_t [3];

  // Load enables of the datapath stages, stage 0 first
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } stage_ctl_t;

endpackage

### rtl/core/spt_stage_ctrl.sv
// Valid bits and per-stage load enables of the transform pipeline.
module spt_stage_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output spt_pkg::stage_ctl_t ctl
);
  import spt_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] room;
  logic [NUM_STAGES-1:0] valid_next;

  // A stage may load when it is empty or the stage after it loads too
  always_comb begin
    room[NUM_STAGES-1] = ~valid[NUM_STAGES-1] | out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      room[k] = ~valid[k] | room[k+1];
    end
  end

  assign valid_next = {valid[NUM_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (room[k]) begin
          valid[k] <= valid_next[k];
        end
      end
    end
  end

  assign ctl.load  = room;
  assign in_ready  = room[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

### rtl/core/spt_rot_matrix.sv
// Rotation matrix from the quaternion registers, two free-running stages.
module spt_rot_matrix (
  input  logic            clk,
  input  spt_pkg::coord_t quat_real,
  input  spt_pkg::coord_t quat_x,
  input  spt_pkg::coord_t quat_y,
  input  spt_pkg::coord_t quat_z,
  output spt_pkg::mat_t   mat
);
  import spt_pkg::*;

  localparam logic signed [QSUM_W-1:0] HALF_Q30 =
    {{(QSUM_W-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

  logic signed [QPROD_W-1:0] rr, xx, yy, zz, xy, xz, yz, rx, ry, rz;
  logic signed [QSUM_W-1:0]  d00, d11, d22, o01, o02, o10, o12, o20, o21;

  function automatic entry_t round_q30(input logic signed [QSUM_W-1:0] v);
    logic signed [QSUM_W-1:0] t;
    t = v + HALF_Q30;
    return entry_t'(t >>> QUAT_FRAC_BITS);
  endfunction

  // Stage one: component products
  always_ff @(posedge clk) begin
    rr <= quat_real * quat_real;
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
    xy <= quat_x * quat_y;
    xz <= quat_x * quat_z;
    yz <= quat_y * quat_z;
    rx <= quat_real * quat_x;
    ry <= quat_real * quat_y;
    rz <= quat_real * quat_z;
  end

  assign d00 = QSUM_W'(rr) + QSUM_W'(xx) - QSUM_W'(yy) - QSUM_W'(zz);
  assign d11 = QSUM_W'(rr) - QSUM_W'(xx) + QSUM_W'(yy) - QSUM_W'(zz);
  assign d22 = QSUM_W'(rr) - QSUM_W'(xx) - QSUM_W'(yy) + QSUM_W'(zz);
  assign o01 = (QSUM_W'(xy) - QSUM_W'(rz)) <<< 1;
  assign o02 = (QSUM_W'(ry) + QSUM_W'(xz)) <<< 1;
  assign o10 = (QSUM_W'(xy) + QSUM_W'(rz)) <<< 1;
  assign o12 = (QSUM_W'(yz) - QSUM_W'(rx)) <<< 1;
  assign o20 = (QSUM_W'(xz) - QSUM_W'(ry)) <<< 1;
  assign o21 = (QSUM_W'(rx) + QSUM_W'(yz)) <<< 1;

  // Stage two: entries rounded to Q30
  always_ff @(posedge clk) begin
    mat[0][0] <= round_q30(d00);
    mat[0][1] <= round_q30(o01);
    mat[0][2] <= round_q30(o02);
    mat[1][0] <= round_q30(o10);
    mat[1][1] <= round_q30(d11);
    mat[1][2] <= round_q30(o12);
    mat[2][0] <= round_q30(o20);
    mat[2][1] <= round_q30(o21);
    mat[2][2] <= round_q30(d22);
  end

endmodule

### rtl/core/spt_rotate.sv
// Point capture, matrix products and row sums: datapath stages 0 to 3.
module spt_rotate (
  input  logic                clk,
  input  spt_pkg::stage_ctl_t ctl,
  input  spt_pkg::coord_t     point_x,
  input  spt_pkg::coord_t     point_y,
  input  spt_pkg::coord_t     point_z,
  input  spt_pkg::mat_t       mat,
  output spt_pkg::sum_vec_t   row_sum
);
  import spt_pkg::*;

  vec_t                     p_in;
  vec_t                     p_dly;
  logic signed [PROD_W-1:0] prod [3][3];

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      p_in[0] <= point_x;
      p_in[1] <= point_y;
      p_in[2] <= point_z;
    end
    // hold one more stage so the matrix has caught up with a fresh write
    if (ctl.load[1]) begin
      p_dly <= p_in;
    end
    if (ctl.load[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= mat[i][j] * p_dly[j];
        end
      end
    end
    if (ctl.load[3]) begin
      for (int i = 0; i < 3; i++) begin
        row_sum[i] <= SUM_W'(prod[i][0]) + SUM_W'(prod[i][1]) + SUM_W'(prod[i][2]);
      end
    end
  end

endmodule

### rtl/core/spt_scale_shift.sv
// Scale, translation, rounding and saturation: datapath stages 4 to 6.
module spt_scale_shift #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                clk,
  input  spt_pkg::stage_ctl_t ctl,
  input  spt_pkg::sum_vec_t   row_sum,
  input  spt_pkg::ucoord_t    scale_factor,
  input  spt_pkg::vec_t       shift,
  output spt_pkg::vec_t       out_pt,
  output logic                clipped
);
  import spt_pkg::*;

  localparam int SH = QUAT_FRAC_BITS + COORD_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SH - 1);
  localparam int TOP_W = ACC_W - SH - COORD_W + 1;

  logic        [LO_PROD_W-1:0] lo_prod [3];
  logic signed [HI_PROD_W-1:0] hi_prod [3];
  logic signed [ACC_W-1:0]     acc [3];
  logic        [TOP_W-1:0]     top [3];
  logic        [2:0]           sat;
  vec_t                        sat_val;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      top[i] = acc[i][ACC_W-1:SH+COORD_W-1];
      sat[i] = ~((&top[i]) | ~(|top[i]));
      if (sat[i]) begin
        sat_val[i] = acc[i][ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                     : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        sat_val[i] = acc[i][SH+COORD_W-1:SH];
      end
    end
  end

  always_ff @(posedge clk) begin
    // split the row sum so each multiply stays near 32 bits
    if (ctl.load[4]) begin
      for (int i = 0; i < 3; i++) begin
        lo_prod[i] <= row_sum[i][SPLIT_W-1:0] * scale_factor;
        hi_prod[i] <= $signed(row_sum[i][SUM_W-1:SPLIT_W]) * $signed({1'b0, scale_factor});
      end
    end
    if (ctl.load[5]) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= (ACC_W'(hi_prod[i]) <<< SPLIT_W)
                + ACC_W'($signed({1'b0, lo_prod[i]}))
                + (ACC_W'(shift[i]) <<< SH)
                + HALF;
      end
    end
    if (ctl.load[6]) begin
      out_pt  <= sat_val;
      clipped <= |sat;
    end
  end

endmodule

### rtl/core/similarity_point_transform.sv
// Top level of the similarity point transform: out = scale * R(q) * p + shift.
//
// One 3D point enters per clock on the slave stream and its transformed point leaves on the
// master stream after seven register stages: capture, matrix alignment, matrix products, row
// sums, scale products, accumulate with translation, round and saturate. A new point is
// taken in every cycle while the pipeline has room; downstream back-pressure stalls only the
// stages that are full, so bubbles close up and the input keeps flowing while a result waits
// until every stage is full. The rotation matrix comes from the quaternion registers as
// given, without normalisation, so |q|^2 scales the point as well. Coordinates, scale and
// translation are Q16.16 (COORD_FRAC_BITS fraction bits), quaternion components Q2.30. Every
// coordinate is rounded to nearest with ties upward and saturated to 32 bits; m_tuser flags
// a transaction in which any coordinate saturated. Write registers over APB only while no
// point is in flight; a point may follow its configuration write in the very next cycle.
module similarity_point_transform #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [95:0]                s_tdata,   // point_x, point_y, point_z
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [95:0]                m_tdata,   // out_x, out_y, out_z
  output logic                       m_tuser,   // clipped
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import spt_pkg::*;

  localparam ucoord_t SCALE_ONE = ucoord_t'(1) << COORD_FRAC_BITS;
  localparam coord_t  QUAT_ONE  = coord_t'(1) << QUAT_FRAC_BITS;

  ucoord_t          scale_factor;
  coord_t           quat_real, quat_x, quat_y, quat_z;
  vec_t             shift;
  logic [IDX_W-1:0] reg_idx;
  logic             reg_wr;

  stage_ctl_t       ctl;
  mat_t             mat;
  sum_vec_t         row_sum;
  vec_t             out_pt;
  logic             clipped;

  // Register port: no wait states, write on the access cycle
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_ONE;
      quat_real    <= QUAT_ONE;
      quat_x       <= '0;
      quat_y       <= '0;
      quat_z       <= '0;
      shift[0]     <= '0;
      shift[1]     <= '0;
      shift[2]     <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_SCALE:     scale_factor <= pwdata;
        REG_QUAT_REAL: quat_real    <= pwdata;
        REG_QUAT_X:    quat_x       <= pwdata;
        REG_QUAT_Y:    quat_y       <= pwdata;
        REG_QUAT_Z:    quat_z       <= pwdata;
        REG_SHIFT_X:   shift[0]     <= pwdata;
        REG_SHIFT_Y:   shift[1]     <= pwdata;
        REG_SHIFT_Z:   shift[2]     <= pwdata;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_SCALE:     prdata = scale_factor;
      REG_QUAT_REAL: prdata = quat_real;
      REG_QUAT_X:    prdata = quat_x;
      REG_QUAT_Y:    prdata = quat_y;
      REG_QUAT_Z:    prdata = quat_z;
      REG_SHIFT_X:   prdata = shift[0];
      REG_SHIFT_Y:   prdata = shift[1];
      REG_SHIFT_Z:   prdata = shift[2];
    endcase
  end

  // Valid bits and stall handling for all datapath stages
  spt_stage_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .ctl       (ctl)
  );

  // The matrix runs freely off the registers; after a write it settles through its product and
  // rounding registers, which the extra alignment stage in front of the point products covers.
  spt_rot_matrix u_matrix (
    .clk       (clk),
    .quat_real (quat_real),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .mat       (mat)
  );

  spt_rotate u_rotate (
    .clk     (clk),
    .ctl     (ctl),
    .point_x (s_tdata[31:0]),
    .point_y (s_tdata[63:32]),
    .point_z (s_tdata[95:64]),
    .mat     (mat),
    .row_sum (row_sum)
  );

  spt_scale_shift #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_scale (
    .clk          (clk),
    .ctl          (ctl),
    .row_sum      (row_sum),
    .scale_factor (scale_factor),
    .shift        (shift),
    .out_pt       (out_pt),
    .clipped      (clipped)
  );

  // Pack the result transaction, x in the lowest bits
  assign m_tdata = {out_pt[2], out_pt[1], out_pt[0]};
  assign m_tuser = clipped;

endmodule

### rtl/core/spt_checker.sv
// Port-level checks on the similarity point transform, bound to its top level.
module spt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic        m_tuser
);

  // No result may be presented straight after reset
  assert property (@(posedge clk) $past(rst) && !rst |-> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed or dropped");

  // With the output ready every stage can advance, so the input must be open
  assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input blocked while output ready");

  // A clipped result carries at least one saturated coordinate
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[31:0]  == 32'h7FFF_FFFF) || (m_tdata[31:0]  == 32'h8000_0000) ||
      (m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000) ||
      (m_tdata[95:64] == 32'h7FFF_FFFF) || (m_tdata[95:64] == 32'h8000_0000))
    else $error("clip flag without a saturated coordinate");

endmodule

bind similarity_point_transform spt_checker u_chk (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for the similarity point transform (scale * R(q) * p + shift).
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spt_pkg::*;

  localparam int FRAC           = 16;    // fraction bits of coordinates, scale and shift
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction before giving up
  localparam int LONG_HOLD      = 300;   // receiver hold-off that fills the pipeline
  localparam int MAX_SHOWN      = 10;    // mismatches printed in full

  // 128-bit signed working type: wide enough for every exact intermediate of the datapath
  typedef logic signed [127:0] wide_t;

  // Point as it travels on s_tdata: x in the lowest 32 bits, then y, then z
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  // Result as it travels on {m_tuser, m_tdata}
  typedef struct packed {
    logic   clipped;
    coord_t z;
    coord_t y;
    coord_t x;
  } result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;   // point_x, point_y, point_z
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;         // out_x, out_y, out_z
  logic        m_tuser;         // clipped
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr  = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor's copy of the register file, reset values as after rst
  logic [31:0] settings [NUM_REGS];

  result_t expected_points [$];   // transformed points still owed by the block

  int errors       = 0;
  int points_done  = 0;
  int points_clip  = 0;
  int reg_writes   = 0;
  int phases_run   = 0;
  int quiet_cycles = 0;
  bit tx_idle      = 1'b0;        // sender inserts random gaps
  bit rx_idle      = 1'b0;        // receiver inserts random stalls
  int rx_hold      = 0;           // one-off long hold-off taken by the receiver

  similarity_point_transform #(
    .COORD_FRAC_BITS(FRAC)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  initial begin
    settings[REG_SCALE]     = 32'h0001_0000;
    settings[REG_QUAT_REAL] = 32'h4000_0000;
    settings[REG_QUAT_X]    = '0;
    settings[REG_QUAT_Y]    = '0;
    settings[REG_QUAT_Z]    = '0;
    settings[REG_SHIFT_X]   = '0;
    settings[REG_SHIFT_Y]   = '0;
    settings[REG_SHIFT_Z]   = '0;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Round to nearest with ties toward plus infinity, then drop k fraction bits
  function automatic wide_t round_half_up(input wide_t v, input int k);
    wide_t one;
    one = 1;
    return (v + (one <<< (k - 1))) >>> k;
  endfunction

  function automatic result_t transform_point(input point_t p);
    wide_t   r, x, y, z, sc, shift, acc, hi_lim, lo_lim;
    wide_t   m [3][3];
    wide_t   v [3];
    coord_t  o [3];
    logic    clip;
    result_t res;
    r  = $signed(settings[REG_QUAT_REAL]);
    x  = $signed(settings[REG_QUAT_X]);
    y  = $signed(settings[REG_QUAT_Y]);
    z  = $signed(settings[REG_QUAT_Z]);
    sc = settings[REG_SCALE];
    v[0] = p.x;
    v[1] = p.y;
    v[2] = p.z;
    hi_lim = 32'sh7FFF_FFFF;
    lo_lim = -hi_lim - 1;
    // Rotation entries: exact Q60 from the component products, then rounded to Q30
    m[0][0] = round_half_up(r*r + x*x - y*y - z*z, QUAT_FRAC_BITS);
    m[0][1] = round_half_up(2 * (x*y - r*z), QUAT_FRAC_BITS);
    m[0][2] = round_half_up(2 * (r*y + x*z), QUAT_FRAC_BITS);
    m[1][0] = round_half_up(2 * (x*y + r*z), QUAT_FRAC_BITS);
    m[1][1] = round_half_up(r*r - x*x + y*y - z*z, QUAT_FRAC_BITS);
    m[1][2] = round_half_up(2 * (y*z - r*x), QUAT_FRAC_BITS);
    m[2][0] = round_half_up(2 * (x*z - r*y), QUAT_FRAC_BITS);
    m[2][1] = round_half_up(2 * (r*x + y*z), QUAT_FRAC_BITS);
    m[2][2] = round_half_up(r*r - x*x - y*y + z*z, QUAT_FRAC_BITS);
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      shift = $signed(settings[REG_SHIFT_X + i]);
      acc = (m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2]) * sc
            + (shift <<< (QUAT_FRAC_BITS + FRAC));
      acc = round_half_up(acc, QUAT_FRAC_BITS + FRAC);
      if (acc > hi_lim) begin
        o[i] = 32'h7FFF_FFFF;
        clip = 1'b1;
      end else if (acc < lo_lim) begin
        o[i] = 32'h8000_0000;
        clip = 1'b1;
      end else begin
        o[i] = acc[31:0];
      end
    end
    res.x       = o[0];
    res.y       = o[1];
    res.z       = o[2];
    res.clipped = clip;
    return res;
  endfunction

  function void note_failure(input string msg);
    if (errors < MAX_SHOWN) begin
      $display("%0t: %s", $realtime, msg);
    end
    errors++;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Scoreboard: sample both streams at the rising edge. Retire the oldest owed point before
  // recording a newly accepted one, so a same-cycle pair never confuses the order.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    string   wrong;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (expected_points.size() == 0) begin
          note_failure($sformatf("unexpected result x=%h y=%h z=%h clipped=%b",
                                 got.x, got.y, got.z, got.clipped));
        end else begin
          want  = expected_points.pop_front();
          wrong = "";
          if (got.x !== want.x) wrong = {wrong, " out_x"};
          if (got.y !== want.y) wrong = {wrong, " out_y"};
          if (got.z !== want.z) wrong = {wrong, " out_z"};
          if (got.clipped !== want.clipped) wrong = {wrong, " clipped"};
          if (wrong != "") begin
            note_failure($sformatf(
              "result %0d wrong in%s: expected x=%h y=%h z=%h c=%b, got x=%h y=%h z=%h c=%b",
              points_done, wrong, want.x, want.y, want.z, want.clipped,
              got.x, got.y, got.z, got.clipped));
          end
        end
        points_done++;
        if (got.clipped === 1'b1) points_clip++;
      end
      if (s_tvalid && s_tready) begin
        expected_points.push_back(transform_point(point_t'(s_tdata)));
      end
    end
  end

  // Watchdog: count cycles in which no transaction completes on any port
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, expected_points.size());
        $display("[similarity_point_transform] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: stall for a random number of cycles (or a requested long hold-off), then take
  // one transaction. Drive at the falling edge, sample at the rising edge.
  // ---------------------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 16) : 0;
      end
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------------------

  // Offer one point after an optional gap; keep tvalid high so back-to-back points stream
  task automatic send_point(input point_t p);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = p;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop the input and wait for every owed result, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (NUM_STAGES + 2) @(negedge clk);
  endtask

  // Two-phase register write; the predictor follows at the accepting edge
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    settings[idx] = value;
    reg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_quat(input logic [31:0] r, x, y, z);
    write_reg(REG_QUAT_REAL, r);
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
  endtask

  task automatic write_shift(input logic [31:0] x, y, z);
    write_reg(REG_SHIFT_X, x);
    write_reg(REG_SHIFT_Y, y);
    write_reg(REG_SHIFT_Z, z);
  endtask

  function automatic point_t make_point(input logic [31:0] x, y, z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // Mostly moderate coordinates (so results stay in range), some corners, some full range
  function automatic coord_t random_coord();
    logic [31:0] corners [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1,
                                 32'hFFFF_FFFF, 32'h0000_8000};
    case ($urandom_range(0, 7))
      0: return corners[$urandom_range(0, 5)];
      1, 2: return $urandom();
      default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endcase
  endfunction

  function automatic point_t random_point();
    return make_point(random_coord(), random_coord(), random_coord());
  endfunction

  function automatic logic [31:0] random_setting(input logic [IDX_W-1:0] idx);
    logic [31:0] corners [5] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(0, 7))
      0: return corners[$urandom_range(0, 4)];
      1: return $urandom();
      default: begin
        if (idx == REG_SCALE) return $urandom_range(0, 32'h0004_0000);
        else if (idx <= REG_QUAT_Z) return $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
        else return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset settings are the identity: every point, extremes included, comes back unchanged
  task automatic test_identity_passthrough();
    send_point(make_point(32'h0, 32'h0, 32'h0));
    send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
    send_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_point(random_point());
    wait_drained();
  endtask

  // Scale of one LSB turns each coordinate into its rounded integer part: halves go upward
  task automatic test_rounding_ties();
    write_reg(REG_SCALE, 32'h0000_0001);
    send_point(make_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000));
    send_point(make_point(32'hFFFE_8000, 32'h0000_7FFF, 32'hFFFF_7FFF));
    wait_drained();
  endtask

  // Zero scale maps any point onto the translation, extremes of the shift included
  task automatic test_zero_scale();
    write_reg(REG_SCALE, 32'h0);
    write_shift(32'h7FFF_FFFF, 32'h8000_0000, $urandom());
    send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_point(random_point());
    wait_drained();
  endtask

  // Quaternion used as given: |q|^2 = 4 scales the rotated point, then a quarter turn about z
  task automatic test_unnormalised_quat();
    write_reg(REG_SCALE, 32'h0001_0000);
    write_shift(32'h0, 32'h0, 32'h0);
    write_quat(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
    send_point(make_point(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000));
    send_point(random_point());
    wait_drained();
    write_quat(32'd759250125, 32'h0, 32'h0, 32'd759250125);
    send_point(make_point(32'h0001_0000, 32'h0, 32'h0));
    wait_drained();
  endtask

  // Largest scale and quaternion drive the coordinates into both saturation limits
  task automatic test_saturation();
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    write_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    write_shift(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    wait_drained();
    write_quat(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    send_point(make_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0));
    wait_drained();
  endtask

  // Random settings per phase, random points, random idling on each side per phase
  task automatic test_random_settings(input int n_phases);
    int per_phase;
    for (int ph = 0; ph < n_phases; ph++) begin
      wait_drained();
      for (int idx = 0; idx < NUM_REGS; idx++) begin
        if ($urandom_range(0, 3) != 0) begin
          write_reg(IDX_W'(idx), random_setting(IDX_W'(idx)));
        end
      end
      tx_idle   = ($urandom_range(0, 2) != 0);
      rx_idle   = ($urandom_range(0, 2) != 0);
      per_phase = $urandom_range(80, 160);
      repeat (per_phase) send_point(random_point());
      phases_run++;
    end
    wait_drained();
  endtask

  // Hold the receiver off while points keep coming at full rate: fill up, stall, recover
  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = LONG_HOLD;
    repeat (80) send_point(random_point());
    wait_drained();
  endtask

  // Pause the sender until the block has answered everything, then resume
  task automatic test_sender_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (30) send_point(random_point());
    wait_drained();
    tx_idle = 1'b0;
    repeat (30) send_point(random_point());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_identity_passthrough();
    test_rounding_ties();
    test_zero_scale();
    test_unnormalised_quat();
    test_saturation();
    test_random_settings(16);
    test_output_backpressure();
    test_sender_pause();

    wait_drained();
    if (expected_points.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_points.size()));
    end
    $display("Checked %0d transformed points (%0d saturated) over %0d random settings",
             points_done, points_clip, phases_run);
    $display("and %0d register writes, with idling, a long output hold-off and a drain pause",
             reg_writes);
    if (errors == 0) begin
      $display("[similarity_point_transform] OK");
    end else begin
      $display("%0d failures", errors);
      $display("[similarity_point_transform] ERROR");
    end
    $finish;
  end

endmodule
